>>> rtl/rgbck_pkg.sv
// ----------------------------------------------------------------------------
// rgbck_pkg
// Types and constants shared by the RGB color key filter modules.
// ----------------------------------------------------------------------------
package rgbck_pkg;

  localparam int PixelW  = 32;
  localparam int ColorW  = 24;
  localparam int ByteW   = 8;
  localparam int SquareW = 16;
  localparam int SumW    = 18;
  localparam int CountW  = 32;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 32;
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = 2;
  localparam int QueueCntW  = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_EXPECTED_COLOR    = 2'd0,
    CFG_DISTANCE_SQUARED  = 2'd1,
    CFG_REPLACEMENT_COLOR = 2'd2,
    CFG_INVERT_MATCH      = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [PixelW-1:0] pixel_in;
    logic              last_pixel;
  } pixel_item_t;

  typedef struct packed {
    logic [PixelW-1:0] pixel_out;
    logic              matched;
    logic [CountW-1:0] match_count;
    logic              last_out;
  } result_item_t;

  // Classified pixel handed from the front end to the back end.
  typedef struct packed {
    logic [PixelW-1:0] pixel;
    logic              matched;
    logic              last;
  } key_item_t;

  typedef struct packed {
    logic [ColorW-1:0] expected_color;
    logic [PixelW-1:0] distance_squared;
    logic [PixelW-1:0] replacement_color;
    logic              invert_match;
  } key_cfg_t;

  function automatic logic [SquareW-1:0] channel_sq(logic [ByteW-1:0] a,
                                                    logic [ByteW-1:0] b);
    logic [ByteW-1:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return SquareW'(d) * SquareW'(d);
  endfunction

endpackage

>>> rtl/rgbck_front.sv
// ----------------------------------------------------------------------------
// rgbck_front
// Two-stage classifier: per-channel squares, then sum and threshold compare.
// ----------------------------------------------------------------------------
module rgbck_front (
  input  logic                     clk,
  input  logic                     rst,
  input  rgbck_pkg::key_cfg_t      cfg,
  input  rgbck_pkg::pixel_item_t   in_item,
  input  logic                     push,
  output logic                     full,
  output rgbck_pkg::key_item_t     q_item,
  output logic                     q_push,
  input  logic                     q_full
);

  logic                          adv;
  logic                          s1_valid;
  logic                          s2_valid;
  logic [rgbck_pkg::SquareW-1:0] sq_r;
  logic [rgbck_pkg::SquareW-1:0] sq_g;
  logic [rgbck_pkg::SquareW-1:0] sq_b;
  logic [rgbck_pkg::PixelW-1:0]  s1_pixel;
  logic                          s1_last;
  logic [rgbck_pkg::SumW-1:0]    sum;
  rgbck_pkg::key_item_t          s2_item;

  assign adv    = !s2_valid || !q_full;
  assign full   = !adv;
  assign q_push = s2_valid && !q_full;
  assign q_item = s2_item;

  assign sum = rgbck_pkg::SumW'(sq_r) + rgbck_pkg::SumW'(sq_g) + rgbck_pkg::SumW'(sq_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= push;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_r     <= rgbck_pkg::channel_sq(in_item.pixel_in[23:16], cfg.expected_color[23:16]);
      sq_g     <= rgbck_pkg::channel_sq(in_item.pixel_in[15:8], cfg.expected_color[15:8]);
      sq_b     <= rgbck_pkg::channel_sq(in_item.pixel_in[7:0], cfg.expected_color[7:0]);
      s1_pixel <= in_item.pixel_in;
      s1_last  <= in_item.last_pixel;
      s2_item.pixel   <= s1_pixel;
      s2_item.last    <= s1_last;
      s2_item.matched <= rgbck_pkg::PixelW'(sum) < cfg.distance_squared;
    end
  end

endmodule

>>> rtl/rgbck_queue.sv
// ----------------------------------------------------------------------------
// rgbck_queue
// Short register queue between the classifier and the output stage.
// ----------------------------------------------------------------------------
module rgbck_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_push,
  input  rgbck_pkg::key_item_t   wr_item,
  output logic                   wr_full,
  output rgbck_pkg::key_item_t   rd_item,
  output logic                   rd_valid,
  input  logic                   rd_pop
);

  rgbck_pkg::key_item_t            mem [rgbck_pkg::QueueDepth];
  logic [rgbck_pkg::QueuePtrW-1:0] wr_ptr;
  logic [rgbck_pkg::QueuePtrW-1:0] rd_ptr;
  logic [rgbck_pkg::QueueCntW-1:0] count;
  logic                            do_wr;
  logic                            do_rd;

  assign wr_full  = count == rgbck_pkg::QueueCntW'(rgbck_pkg::QueueDepth);
  assign rd_valid = count != '0;
  assign do_wr    = wr_push && !wr_full;
  assign do_rd    = rd_pop && rd_valid;
  assign rd_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      if (do_wr && !do_rd) count <= count + 1'b1;
      else if (!do_wr && do_rd) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wr_item;
  end

endmodule

>>> rtl/rgbck_back.sv
// ----------------------------------------------------------------------------
// rgbck_back
// Match counter, pixel replacement and the result register.
// ----------------------------------------------------------------------------
module rgbck_back (
  input  logic                     clk,
  input  logic                     rst,
  input  rgbck_pkg::key_cfg_t      cfg,
  input  rgbck_pkg::key_item_t     q_item,
  input  logic                     q_valid,
  output logic                     q_pop,
  output rgbck_pkg::result_item_t  result_item,
  output logic                     empty,
  input  logic                     pop
);

  logic                         out_valid;
  logic [rgbck_pkg::CountW-1:0] match_counter;
  logic [rgbck_pkg::CountW-1:0] count_next;
  logic                         load;
  logic                         keep;

  assign load  = !out_valid || pop;
  assign q_pop = q_valid && load;
  assign empty = !out_valid;
  assign keep  = q_item.matched != cfg.invert_match;

  always_comb begin
    count_next = match_counter;
    if (q_item.matched && match_counter != '1) count_next = match_counter + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      match_counter <= '0;
    end else if (load) begin
      out_valid <= q_valid;
      if (q_valid) match_counter <= q_item.last ? '0 : count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      result_item.pixel_out   <= keep ? q_item.pixel : cfg.replacement_color;
      result_item.matched     <= q_item.matched;
      result_item.match_count <= count_next;
      result_item.last_out    <= q_item.last;
    end
  end

endmodule

>>> rtl/rgb_euclidean_color_key_filter_top.sv
// ----------------------------------------------------------------------------
// rgb_euclidean_color_key_filter_top
// Color key filter: keeps or replaces ARGB pixels by squared RGB distance.
//
//   channel   handshake          payload
//   input     push / full        in_item     (pixel_in, last_pixel)
//   result    pop / empty        result_item (pixel_out, matched, match_count,
//                                             last_out)
//   config    cfg_we             cfg_index, cfg_data
//
// One pixel is taken per clock while full is low. Squares, then sum and
// compare, each take a register stage; a 4-entry queue lets the output
// register stall without stopping the classifier at once.
// Reset clears the stage valids, queue, match counter and config registers.
// full rises when the queue is full and the second stage holds a pixel.
// ----------------------------------------------------------------------------
module rgb_euclidean_color_key_filter_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [rgbck_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [rgbck_pkg::CfgDataW-1:0]      cfg_data,
  input  rgbck_pkg::pixel_item_t              in_item,
  input  logic                                push,
  output logic                                full,
  output rgbck_pkg::result_item_t             result_item,
  output logic                                empty,
  input  logic                                pop
);

  rgbck_pkg::key_cfg_t  cfg;
  rgbck_pkg::key_item_t f_item;
  rgbck_pkg::key_item_t q_item;
  logic                 f_push;
  logic                 q_full;
  logic                 q_valid;
  logic                 q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (rgbck_pkg::cfg_index_t'(cfg_index))
        rgbck_pkg::CFG_EXPECTED_COLOR:
          cfg.expected_color <= cfg_data[rgbck_pkg::ColorW-1:0];
        rgbck_pkg::CFG_DISTANCE_SQUARED:  cfg.distance_squared  <= cfg_data;
        rgbck_pkg::CFG_REPLACEMENT_COLOR: cfg.replacement_color <= cfg_data;
        rgbck_pkg::CFG_INVERT_MATCH:      cfg.invert_match      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  rgbck_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .in_item (in_item),
    .push    (push),
    .full    (full),
    .q_item  (f_item),
    .q_push  (f_push),
    .q_full  (q_full)
  );

  rgbck_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_push  (f_push),
    .wr_item  (f_item),
    .wr_full  (q_full),
    .rd_item  (q_item),
    .rd_valid (q_valid),
    .rd_pop   (q_pop)
  );

  rgbck_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_item      (q_item),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .result_item (result_item),
    .empty       (empty),
    .pop         (pop)
  );

endmodule

>>> rtl/rgbck_checker.sv
// ----------------------------------------------------------------------------
// rgbck_checker
// Port-level checks on the color key filter, bound to the top level.
// ----------------------------------------------------------------------------
module rgbck_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            push,
  input logic                            full,
  input rgbck_pkg::result_item_t         result_item,
  input logic                            empty,
  input logic                            pop
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result visible right after reset");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result_item)))
    else $error("stalled result changed");

  a_match_counted: assert property (@(posedge clk) disable iff (rst)
    (!empty && result_item.matched) |-> (result_item.match_count != '0))
    else $error("matched beat with zero count");

  a_no_full_after_reset: assert property (@(posedge clk) rst |=> !full)
    else $error("full asserted right after reset");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !result_item.last_out && !result_item.matched) ##1
    (!empty && !result_item.matched && !$past(rst)) |->
    (result_item.match_count == $past(result_item.match_count)))
    else $error("count moved on an unmatched beat");

endmodule

bind rgb_euclidean_color_key_filter_top rgbck_checker u_rgbck_checker (
  .clk         (clk),
  .rst         (rst),
  .push        (push),
  .full        (full),
  .result_item (result_item),
  .empty       (empty),
  .pop         (pop)
);
